@@ design/lrmm_pkg.sv @@
// shared types, register codes and helpers for the line running max/min filter
// no dependencies; every other file of the block imports this package
package lrmm_pkg;

  localparam int unsigned MAX_HALF_DEF = 31;
  localparam int unsigned PIX_W        = 16;
  localparam int unsigned CFG_W        = 5;

  typedef enum logic {
    REG_HALF_WINDOW = 1'b0,
    REG_OPERATION   = 1'b1
  } reg_idx_e;

  typedef enum logic {
    OP_DILATE = 1'b0,
    OP_ERODE  = 1'b1
  } op_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             last_in_line;
  } pix_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             last_out;
  } pix_out_t;

  // fixed-width part of a classified pixel
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
    logic             main;
    op_e              op;
  } job_t;

  // tag that travels with each reduction through the tree
  typedef struct packed {
    logic vld;
    logic last;
    op_e  op;
  } tag_t;

  function automatic logic [PIX_W-1:0] pick(op_e op, logic [PIX_W-1:0] a,
                                           logic [PIX_W-1:0] b);
    logic [PIX_W-1:0] r;
    if (op == OP_ERODE) begin
      r = (b < a) ? b : a;
    end else begin
      r = (b > a) ? b : a;
    end
    return r;
  endfunction

  // neutral value for padding leaves
  function automatic logic [PIX_W-1:0] neutral(op_e op);
    return (op == OP_ERODE) ? {PIX_W{1'b1}} : {PIX_W{1'b0}};
  endfunction

endpackage

@@ design/line_running_max_min_filter_core.sv @@
// top level of the line running max/min filter (1-D grayscale dilation / erosion)
// depends on lrmm_pkg, lrmm_front, lrmm_queue, lrmm_back, lrmm_tree
//
//   port group   direction   handshake              payload
//   in_*         input       in_valid_i/in_ready_o  pix_in_t (pixel_in, last_in_line)
//   out_*        output      out_valid_o/out_ready_i pix_out_t (pixel_out, last_out)
//   cfg_*        input       cfg_we_i               cfg_idx_i, cfg_data_i
//
// one pixel per clock in steady state unless output stalls; the last pixel of a line
// adds up to half_window extra outputs, one per clock, while the back end sequencer
// holds input; requests pass through the registered levels of the compare tree
// reset is asynchronous and clears control only; the window needs no clearing pass
// a stalled output freezes the tree and sequencer; the two-entry queue absorbs the front
module line_running_max_min_filter_core #(
  parameter int unsigned MAX_HALF = lrmm_pkg::MAX_HALF_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [lrmm_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  lrmm_pkg::pix_in_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output lrmm_pkg::pix_out_t          out_data_o
);
  import lrmm_pkg::*;

  localparam int unsigned DEPTH = 2 * MAX_HALF + 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HALF + 1);
  localparam int unsigned QW    = $bits(job_t) + 2 * CW + 2 * HW;

  logic          f_valid, f_ready;
  job_t          f_job;
  logic [CW-1:0] f_avail, f_seen;
  logic [HW-1:0] f_half, f_rem;

  logic          b_valid, b_ready;
  job_t          b_job;
  logic [CW-1:0] b_avail, b_seen;
  logic [HW-1:0] b_half, b_rem;
  logic [QW-1:0] q_out;

  logic [PIX_W-1:0] window [DEPTH];
  tag_t             req;
  logic [CW-1:0]    req_count;
  logic             adv;

  lrmm_front #(.MAX_HALF(MAX_HALF)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .job_valid_o (f_valid),
    .job_ready_i (f_ready),
    .job_o       (f_job),
    .job_avail_o (f_avail),
    .job_seen_o  (f_seen),
    .job_half_o  (f_half),
    .job_rem_o   (f_rem)
  );

  lrmm_queue #(.W(QW)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  ({f_job, f_avail, f_seen, f_half, f_rem}),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (q_out)
  );

  assign {b_job, b_avail, b_seen, b_half, b_rem} = q_out;

  lrmm_back #(.MAX_HALF(MAX_HALF)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (b_valid),
    .job_ready_o (b_ready),
    .job_i       (b_job),
    .job_avail_i (b_avail),
    .job_seen_i  (b_seen),
    .job_half_i  (b_half),
    .job_rem_i   (b_rem),
    .adv_i       (adv),
    .window_o    (window),
    .req_o       (req),
    .req_count_o (req_count)
  );

  lrmm_tree #(.MAX_HALF(MAX_HALF)) u_tree (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .window_i    (window),
    .req_i       (req),
    .count_i     (req_count),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // every reduction covers at least the newest pixel and never more than the window
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.vld |-> (req_count != '0) && (req_count <= CW'(DEPTH)))
    else $error("reduction count out of range");

  // a pixel that produces no main output can only occur with a nonzero half window
  a_no_main_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_valid && f_ready && !f_job.main) |-> (f_half != '0))
    else $error("silent pixel with zero half window");

  // a pending request holds while the tree is stalled
  a_req_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.vld && !adv) |=> (req.vld && $stable(req_count) && $stable(req.last)))
    else $error("request changed during stall");

endmodule

@@ design/lrmm_front.sv @@
// front end: configuration registers, per-line pixel count and request classification
// depends on lrmm_pkg
module lrmm_front #(
  parameter int unsigned MAX_HALF = lrmm_pkg::MAX_HALF_DEF,
  localparam int unsigned DEPTH = 2 * MAX_HALF + 1,
  localparam int unsigned CW = $clog2(DEPTH + 1),
  localparam int unsigned HW = $clog2(MAX_HALF + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [0:0]                  cfg_idx_i,
  input  logic [lrmm_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  lrmm_pkg::pix_in_t           in_data_i,
  output logic                        job_valid_o,
  input  logic                        job_ready_i,
  output lrmm_pkg::job_t              job_o,
  output logic [CW-1:0]               job_avail_o,
  output logic [CW-1:0]               job_seen_o,
  output logic [HW-1:0]               job_half_o,
  output logic [HW-1:0]               job_rem_o
);
  import lrmm_pkg::*;

  logic [CFG_W-1:0] half_q;
  op_e              op_q;
  logic [CW-1:0]    seen_q, seen_d;
  logic [HW-1:0]    half_c;
  logic [CW-1:0]    seen_inc, span_c;
  logic             accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= CFG_W'(1);
      op_q   <= OP_DILATE;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_HALF_WINDOW: half_q <= cfg_data_i;
        REG_OPERATION:   op_q   <= op_e'(cfg_data_i[0]);
        default:         half_q <= half_q;
      endcase
    end
  end

  always_comb begin
    half_c   = (half_q > MAX_HALF) ? HW'(MAX_HALF) : HW'(half_q);
    seen_inc = (seen_q == CW'(DEPTH)) ? seen_q : seen_q + 1'b1;
    span_c   = CW'({half_c, 1'b1});
  end

  assign accept      = in_valid_i & job_ready_i;
  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;

  always_comb begin
    job_o.pixel = in_data_i.pixel_in;
    job_o.last  = in_data_i.last_in_line;
    job_o.main  = seen_inc > CW'(half_c);
    job_o.op    = op_q;
    job_avail_o = (seen_inc < span_c) ? seen_inc : span_c;
    job_seen_o  = seen_inc;
    job_half_o  = half_c;
    // flush length is the smaller of pixels seen and the half window
    job_rem_o   = (seen_inc < CW'(half_c)) ? HW'(seen_inc) : half_c;
  end

  assign seen_d = in_data_i.last_in_line ? '0 : seen_inc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
    end else if (accept) begin
      seen_q <= seen_d;
    end
  end

endmodule

@@ design/lrmm_queue.sv @@
// two-entry request queue between front end and back end
// depends on lrmm_pkg only for house style; payload is a flat vector
module lrmm_queue #(
  parameter int unsigned W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);
  import lrmm_pkg::*;

  logic [W-1:0] mem_q [2];
  logic         wr_ptr_q, rd_ptr_q;
  logic [1:0]   cnt_q;
  logic         push, pop;

  assign push_ready_o = (cnt_q != 2'd2);
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ design/lrmm_back.sv @@
// back end: pixel window shift line and output sequencer (main output, then flush)
// depends on lrmm_pkg
module lrmm_back #(
  parameter int unsigned MAX_HALF = lrmm_pkg::MAX_HALF_DEF,
  localparam int unsigned DEPTH = 2 * MAX_HALF + 1,
  localparam int unsigned CW = $clog2(DEPTH + 1),
  localparam int unsigned HW = $clog2(MAX_HALF + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        job_valid_i,
  output logic                        job_ready_o,
  input  lrmm_pkg::job_t              job_i,
  input  logic [CW-1:0]               job_avail_i,
  input  logic [CW-1:0]               job_seen_i,
  input  logic [HW-1:0]               job_half_i,
  input  logic [HW-1:0]               job_rem_i,
  input  logic                        adv_i,
  output logic [lrmm_pkg::PIX_W-1:0]  window_o [DEPTH],
  output lrmm_pkg::tag_t              req_o,
  output logic [CW-1:0]               req_count_o
);
  import lrmm_pkg::*;

  logic [PIX_W-1:0] win_q [DEPTH];
  logic             busy_q, main_q, last_q;
  op_e              op_q;
  logic [HW-1:0]    d_q, half_q;
  logic [CW-1:0]    avail_q, seen_q;
  logic [CW-1:0]    flush_w, flush_cnt;
  logic             fin, issue, pop;

  // final request of the current pixel
  assign fin   = main_q ? (d_q == '0) : (d_q == HW'(1));
  assign issue = busy_q & adv_i;
  assign job_ready_o = ~busy_q | (issue & fin);
  assign pop   = job_valid_i & job_ready_o;

  always_comb begin
    flush_w     = CW'(d_q) + CW'(half_q);
    flush_cnt   = (seen_q < flush_w) ? seen_q : flush_w;
    req_o.vld   = busy_q;
    req_o.last  = fin & last_q;
    req_o.op    = op_q;
    req_count_o = main_q ? avail_q : flush_cnt;
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      win_q[0] <= job_i.pixel;
      for (int i = 1; i < DEPTH; i++) begin
        win_q[i] <= win_q[i-1];
      end
      last_q  <= job_i.last;
      op_q    <= job_i.op;
      avail_q <= job_avail_i;
      seen_q  <= job_seen_i;
      half_q  <= job_half_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      main_q <= 1'b0;
      d_q    <= '0;
    end else if (pop) begin
      busy_q <= job_i.main | job_i.last;
      main_q <= job_i.main;
      d_q    <= job_i.last ? job_rem_i : '0;
    end else if (issue) begin
      if (fin) begin
        busy_q <= 1'b0;
      end else if (main_q) begin
        main_q <= 1'b0;
      end else begin
        d_q <= d_q - 1'b1;
      end
    end
  end

  assign window_o = win_q;

endmodule

@@ design/lrmm_tree.sv @@
// registered reduction tree: masks the window by count, one compare level per stage
// depends on lrmm_pkg
module lrmm_tree #(
  parameter int unsigned MAX_HALF = lrmm_pkg::MAX_HALF_DEF,
  localparam int unsigned DEPTH = 2 * MAX_HALF + 1,
  localparam int unsigned CW = $clog2(DEPTH + 1),
  localparam int unsigned LVL = $clog2(DEPTH),
  localparam int unsigned NLEAF = 2 ** LVL,
  localparam int unsigned NNODE = NLEAF - 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [lrmm_pkg::PIX_W-1:0]  window_i [DEPTH],
  input  lrmm_pkg::tag_t              req_i,
  input  logic [CW-1:0]               count_i,
  output logic                        adv_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output lrmm_pkg::pix_out_t          out_data_o
);
  import lrmm_pkg::*;

  logic [PIX_W-1:0] leaf [NLEAF];
  logic [PIX_W-1:0] node_q [NNODE];
  tag_t             tag_q [LVL];

  assign adv_o = ~tag_q[0].vld | out_ready_i;

  for (genvar j = 0; j < NLEAF; j++) begin : g_leaf
    if (j < DEPTH) begin : g_real
      assign leaf[j] = (CW'(j) < count_i) ? window_i[j] : neutral(req_i.op);
    end else begin : g_pad
      assign leaf[j] = neutral(req_i.op);
    end
  end

  // heap layout: node n has children 2n+1 and 2n+2, root at 0
  for (genvar n = 0; n < NNODE; n++) begin : g_node
    localparam int unsigned DN = $clog2(n + 2) - 1;
    logic [PIX_W-1:0] a, b;
    op_e              op;
    if (2 * n + 1 >= NNODE) begin : g_bottom
      assign a  = leaf[2*n+1-NNODE];
      assign b  = leaf[2*n+2-NNODE];
      assign op = req_i.op;
    end else begin : g_inner
      assign a  = node_q[2*n+1];
      assign b  = node_q[2*n+2];
      assign op = tag_q[DN+1].op;
    end
    always_ff @(posedge clk_i) begin
      if (adv_o) begin
        node_q[n] <= pick(op, a, b);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LVL; k++) begin
        tag_q[k] <= '0;
      end
    end else if (adv_o) begin
      for (int k = 0; k < LVL - 1; k++) begin
        tag_q[k] <= tag_q[k+1];
      end
      tag_q[LVL-1] <= req_i;
    end
  end

  assign out_valid_o          = tag_q[0].vld;
  assign out_data_o.pixel_out = node_q[0];
  assign out_data_o.last_out  = tag_q[0].last;

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for line_running_max_min_filter_core (1-D dilation / erosion)
// depends on lrmm_pkg and the core; a scoreboard class predicts every filtered pixel
// and checks the output stream under random input gaps and output stalls
module testbench;
  import lrmm_pkg::*;

  localparam int unsigned STORE_DEPTH = 2 * MAX_HALF_DEF + 1;
  localparam int unsigned SETTLE      = 16;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned RAND_PIXELS = 205;

  typedef enum int unsigned {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_HOLD
  } rx_mode_e;

  class filter_scoreboard;
    logic [PIX_W-1:0] line_buf [STORE_DEPTH];
    int unsigned      seen;
    int unsigned      half;
    op_e              op;
    pix_out_t         pending_pixels[$];
    int unsigned      mismatches;
    int unsigned      checked;

    function new();
      foreach (line_buf[j]) line_buf[j] = '0;
      seen       = 0;
      half       = 1;
      op         = OP_DILATE;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_HALF_WINDOW: half = data;
        REG_OPERATION:   op = op_e'(data[0]);
        default: ;
      endcase
    endfunction

    // combine the newest count pixels of the line
    function logic [PIX_W-1:0] reduce(int unsigned count);
      logic [PIX_W-1:0] acc;
      acc = line_buf[0];
      for (int unsigned j = 1; j < count; j++) begin
        if (op == OP_ERODE) begin
          if (line_buf[j] < acc) acc = line_buf[j];
        end else begin
          if (line_buf[j] > acc) acc = line_buf[j];
        end
      end
      return acc;
    endfunction

    function void take_pixel(pix_in_t item);
      int unsigned h;
      int unsigned span;
      int unsigned avail;
      int unsigned rem;
      int unsigned want;
      int unsigned n;
      h    = (half > MAX_HALF_DEF) ? MAX_HALF_DEF : half;
      span = 2 * h + 1;
      n    = 0;
      for (int j = STORE_DEPTH - 1; j > 0; j--) line_buf[j] = line_buf[j-1];
      line_buf[0] = item.pixel_in;
      if (seen < STORE_DEPTH) seen++;
      avail = (seen < span) ? seen : span;
      if (seen > h) begin
        pending_pixels.push_back('{pixel_out: reduce(avail), last_out: 1'b0});
        n++;
      end
      if (item.last_in_line) begin
        // flush the tail of the line, window clipped at the end
        rem = (seen < h) ? seen : h;
        for (int unsigned d = rem; d > 0; d--) begin
          want = d + h;
          pending_pixels.push_back('{pixel_out: reduce((seen < want) ? seen : want),
                                     last_out: 1'b0});
          n++;
        end
        if (n > 0) pending_pixels[pending_pixels.size()-1].last_out = 1'b1;
        seen = 0;
      end
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch %0d: %s", mismatches, msg);
    endfunction

    function void check_output(pix_out_t got);
      pix_out_t want;
      if (pending_pixels.size() == 0) begin
        note_mismatch($sformatf("unexpected output pixel %h last %b",
                                got.pixel_out, got.last_out));
      end else begin
        want = pending_pixels.pop_front();
        checked++;
        if (got.pixel_out !== want.pixel_out || got.last_out !== want.last_out) begin
          note_mismatch($sformatf("expected pixel %h last %b, got pixel %h last %b",
                                  want.pixel_out, want.last_out,
                                  got.pixel_out, got.last_out));
        end
      end
    endfunction

    function int unsigned pending();
      return pending_pixels.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [0:0]         cfg_idx_i;
  logic [CFG_W-1:0]   cfg_data_i;
  logic               in_valid_i;
  logic               in_ready_o;
  pix_in_t            in_data_i;
  logic               out_valid_o;
  logic               out_ready_i;
  pix_out_t           out_data_o;

  filter_scoreboard   sb = new();

  int unsigned        burst_left = 0;
  int unsigned        gap_left = 0;
  int unsigned        pixels_sent = 0;
  int unsigned        lines_sent = 0;
  int unsigned        erode_lines = 0;
  int unsigned        dilate_lines = 0;
  int unsigned        half_lo = 31;
  int unsigned        half_hi = 0;
  int unsigned        idle_cycles = 0;
  rx_mode_e           rx_mode = RX_OPEN;
  int unsigned        rx_left = 0;

  line_running_max_min_filter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // output checker, receiver stall pattern and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_output(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(4, 40);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:   out_ready_i <= 1'b1;
      RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:   out_ready_i <= 1'b0;
    endcase
  end

  // one request; valid stays up across a burst
  task automatic send_pixel(logic [PIX_W-1:0] value, logic last);
    pix_in_t item;
    item = '{pixel_in: value, last_in_line: last};
    if (gap_left > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap_left) @(posedge clk_i);
      gap_left = 0;
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.take_pixel(item);
    pixels_sent++;
    if (last) begin
      lines_sent++;
      if (sb.op == OP_ERODE) erode_lines++;
      else dilate_lines++;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end else begin
      burst_left--;
    end
  endtask

  // stop input, let every expected pixel out, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_config(logic [CFG_W-1:0] half, op_e op);
    logic [CFG_W-1:0] op_word;
    // upper bits of the operation word are don't-care
    op_word    = {4'($urandom), op};
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_HALF_WINDOW;
    cfg_data_i <= half;
    @(posedge clk_i);
    sb.set_reg(REG_HALF_WINDOW, half);
    cfg_idx_i  <= REG_OPERATION;
    cfg_data_i <= op_word;
    @(posedge clk_i);
    sb.set_reg(REG_OPERATION, op_word);
    cfg_we_i   <= 1'b0;
    if (half < half_lo) half_lo = half;
    if (half > half_hi) half_hi = half;
  endtask

  initial begin
    int unsigned      r;
    int unsigned      len;
    int unsigned      rand_start;
    logic [CFG_W-1:0] h;
    logic [PIX_W-1:0] base;
    logic [PIX_W-1:0] v;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_HALF_WINDOW;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: half window 1, dilation
    half_lo = 1;
    half_hi = 1;
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h5555, 1'b0);
    send_pixel(16'hAAAA, 1'b1);

    // zero half window passes pixels straight through
    drain();
    write_config(5'd0, OP_ERODE);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'h8000, 1'b1);

    // line shorter than the window, all outputs come at the last pixel
    drain();
    write_config(5'd31, OP_DILATE);
    send_pixel(16'h1234, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b1);
    drain();
    write_config(5'd31, OP_ERODE);
    send_pixel(16'h7FFF, 1'b1);

    // settings change in the middle of a line
    drain();
    write_config(5'd2, OP_ERODE);
    send_pixel(16'h00FF, 1'b0);
    send_pixel(16'hFF00, 1'b0);
    send_pixel(16'h0F0F, 1'b0);
    drain();
    write_config(5'd5, OP_DILATE);
    send_pixel(16'hF0F0, 1'b0);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'hFFFE, 1'b1);

    drain();
    write_config(5'd1, OP_ERODE);
    send_pixel(16'h9999, 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(16'h6666, 1'b0);
    send_pixel(16'h0001, 1'b1);

    // random lines, mostly short, now and then longer than the whole store
    rand_start = pixels_sent;
    while (pixels_sent - rand_start < RAND_PIXELS) begin
      if ($urandom_range(0, 1) == 1) begin
        r = $urandom_range(0, 9);
        if (r == 0) h = 5'd0;
        else if (r == 1) h = 5'd31;
        else if (r < 4) h = 5'($urandom_range(0, 31));
        else h = 5'($urandom_range(1, 4));
        drain();
        write_config(h, op_e'($urandom_range(0, 1)));
      end
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 10);
      base = 16'($urandom);
      for (int unsigned k = 0; k < len; k++) begin
        r = $urandom_range(0, 5);
        if (r == 0) v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else if (r == 1) v = base + 16'($urandom_range(0, 3));
        else v = 16'($urandom);
        send_pixel(v, k == len - 1);
      end
    end

    drain();
    $display("ran %0d lines (%0d dilation, %0d erosion), %0d pixels in, %0d outputs checked",
             lines_sent, dilate_lines, erode_lines, pixels_sent, sb.checked);
    $display("half window settings spanned %0d to %0d", half_lo, half_hi);
    if (sb.pending() != 0) $display("%0d expected outputs never arrived", sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/lrmm_pkg.sv
design/lrmm_front.sv
design/lrmm_queue.sv
design/lrmm_back.sv
design/lrmm_tree.sv
design/line_running_max_min_filter_core.sv
tb/testbench.sv
